FILE: sv/lob_pkg.sv
// shared types, codes and defaults for the limit order book
`timescale 1ns / 1ps
package lob_pkg;

	// default sizes
	localparam int ORDERS_DEF     = 1024;
	localparam int LEVELS_DEF     = 64;
	localparam int PRICE_BITS_DEF = 32;
	localparam int ENTRY_W_DEF    = 64 + PRICE_BITS_DEF + 1 + $clog2(ORDERS_DEF);

	// command codes
	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_CANCEL = 1'b1;

	// side codes
	localparam logic SIDE_BID = 1'b0;
	localparam logic SIDE_ASK = 1'b1;

	// status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_DUP     = 2'd3;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_PASS1,
		S_PASS2,
		S_FIN
	} state_t;

	// request beat
	typedef struct packed {
		logic        cmd;
		logic [63:0] order_id;
		logic [31:0] price;
		logic        side;
	} req_t;

	// response beat
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] best_bid;
		logic        bid_valid;
		logic [31:0] best_ask;
		logic        ask_valid;
		logic [63:0] bid_front_id;
		logic [63:0] ask_front_id;
	} rsp_t;

endpackage

FILE: sv/lob_cell.sv
// one order cell of the circulating order ring
`timescale 1ns / 1ps
module lob_cell #(
	parameter int DW = lob_pkg::ENTRY_W_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  logic          nxt_vld,
	input  logic [DW-1:0] nxt_data,
	output logic          vld,
	output logic [DW-1:0] data
);
	import lob_pkg::*;

	logic          vld_q;
	logic [DW-1:0] data_q;

	// occupancy mark, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (shift) begin
			vld_q <= nxt_vld;
		end
	end

	// order payload moves one cell toward the head on each shift
	always_ff @(posedge clk) begin
		if (shift && nxt_vld) begin
			data_q <= nxt_data;
		end
	end

	assign vld  = vld_q;
	assign data = data_q;

endmodule

FILE: sv/lob_unit.sv
// head unit: sequencer, per-order processing and book bookkeeping
`timescale 1ns / 1ps
module lob_unit #(
	parameter int MAX_ORDERS = lob_pkg::ORDERS_DEF,
	parameter int MAX_LEVELS = lob_pkg::LEVELS_DEF,
	parameter int PRICE_BITS = lob_pkg::PRICE_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  lob_pkg::req_t                                 req,
	input  logic                                          req_valid,
	output logic                                          req_stall,
	output lob_pkg::rsp_t                                 rsp,
	output logic                                          rsp_valid,
	input  logic                                          rsp_stall,
	input  logic                                          head_vld,
	input  logic [64+PRICE_BITS+1+$clog2(MAX_ORDERS)-1:0] head_data,
	output logic                                          shift,
	output logic                                          tail_vld,
	output logic [64+PRICE_BITS+1+$clog2(MAX_ORDERS)-1:0] tail_data
);
	import lob_pkg::*;

	localparam int RW  = $clog2(MAX_ORDERS);
	localparam int OCW = $clog2(MAX_ORDERS + 1);
	localparam int LCW = $clog2(MAX_LEVELS + 1);
	localparam int PB  = PRICE_BITS;
	localparam logic [RW-1:0]  LAST_POS = RW'(MAX_ORDERS - 1);
	localparam logic [OCW-1:0] ORD_FULL = OCW'(MAX_ORDERS);
	localparam logic [LCW-1:0] LVL_FULL = LCW'(MAX_LEVELS);

	state_t state_q, state_d;
	logic [RW-1:0] pos_q;

	// captured request
	logic          r_cmd_q;
	logic [63:0]   r_id_q;
	logic [PB-1:0] r_price_q;
	logic          r_side_q;

	// first pass findings
	logic          hit_q;
	logic          lvl_q;
	logic [PB-1:0] f_price_q;
	logic          f_side_q;
	logic [RW-1:0] f_rank_q;

	// second pass accumulators
	logic          ins_q;
	logic          remain_q;
	logic          bbv_q, abv_q;
	logic [PB-1:0] bb_q, ab_q;
	logic [RW-1:0] bbr_q, abr_q;
	logic [63:0]   bbf_q, abf_q;

	// book sizes
	logic [OCW-1:0] ord_cnt_q;
	logic [LCW-1:0] bid_cnt_q, ask_cnt_q;

	rsp_t rsp_q;
	logic rsp_valid_q;

	// head entry fields
	logic [63:0]   h_id;
	logic [PB-1:0] h_price;
	logic          h_side;
	logic [RW-1:0] h_rank;

	assign h_id    = head_data[RW+1+PB +: 64];
	assign h_price = head_data[RW+1 +: PB];
	assign h_side  = head_data[RW];
	assign h_rank  = head_data[RW-1:0];

	// outgoing entry fields
	logic          y_vld;
	logic [63:0]   y_id;
	logic [PB-1:0] y_price;
	logic          y_side;
	logic [RW-1:0] y_rank;

	logic id_hit, lvl_hit, add_ok, cancel_ok, ins_now;
	logic bid_take, ask_take, remain_hit, out_free, fin_leave;
	logic [LCW-1:0] side_cnt;
	logic [1:0] status;

	// decision from first pass
	assign side_cnt  = (r_side_q == SIDE_ASK) ? ask_cnt_q : bid_cnt_q;
	assign add_ok    = (r_cmd_q == CMD_ADD) && !hit_q && (ord_cnt_q != ORD_FULL) &&
		(lvl_q || (side_cnt != LVL_FULL));
	assign cancel_ok = (r_cmd_q == CMD_CANCEL) && hit_q;

	always_comb begin
		if (r_cmd_q == CMD_CANCEL) begin
			status = hit_q ? ST_DONE : ST_UNKNOWN;
		end else if (hit_q) begin
			status = ST_DUP;
		end else begin
			status = add_ok ? ST_DONE : ST_FULL;
		end
	end

	// first pass compares
	assign id_hit  = head_vld && (h_id == r_id_q);
	assign lvl_hit = head_vld && (h_side == r_side_q) && (h_price == r_price_q);

	// second pass rewrite of the entry leaving the head
	assign ins_now = (state_q == S_PASS2) && add_ok && !head_vld && !ins_q;

	always_comb begin
		y_vld   = head_vld;
		y_id    = h_id;
		y_price = h_price;
		y_side  = h_side;
		y_rank  = h_rank;
		if (state_q == S_PASS2) begin
			if (ins_now) begin
				y_vld   = 1'b1;
				y_id    = r_id_q;
				y_price = r_price_q;
				y_side  = r_side_q;
				y_rank  = '0;
			end else if (add_ok && head_vld) begin
				y_rank = h_rank + RW'(1);
			end else if (cancel_ok && head_vld) begin
				if (h_rank == f_rank_q) begin
					y_vld = 1'b0;
				end else if (h_rank > f_rank_q) begin
					y_rank = h_rank - RW'(1);
				end
			end
		end
	end

	assign tail_vld  = y_vld;
	assign tail_data = {y_id, y_price, y_side, y_rank};

	// best level tracking, older order wins a price tie
	assign bid_take = y_vld && (y_side == SIDE_BID) &&
		(!bbv_q || (y_price > bb_q) || ((y_price == bb_q) && (y_rank > bbr_q)));
	assign ask_take = y_vld && (y_side == SIDE_ASK) &&
		(!abv_q || (y_price < ab_q) || ((y_price == ab_q) && (y_rank > abr_q)));
	assign remain_hit = y_vld && (y_side == f_side_q) && (y_price == f_price_q);

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign fin_leave = (state_q == S_FIN) && out_free;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (req_valid) state_d = S_PASS1;
			S_PASS1: if (pos_q == LAST_POS) state_d = S_PASS2;
			S_PASS2: if (pos_q == LAST_POS) state_d = S_FIN;
			S_FIN:   if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		req_stall = 1'b1;
		shift     = 1'b0;
		case (state_q)
			S_IDLE:  req_stall = 1'b0;
			S_PASS1: shift = 1'b1;
			S_PASS2: shift = 1'b1;
			S_FIN:   req_stall = 1'b1;
			default: req_stall = 1'b1;
		endcase
	end

	// state, position and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			hit_q       <= 1'b0;
			lvl_q       <= 1'b0;
			ins_q       <= 1'b0;
			remain_q    <= 1'b0;
			bbv_q       <= 1'b0;
			abv_q       <= 1'b0;
			ord_cnt_q   <= '0;
			bid_cnt_q   <= '0;
			ask_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					pos_q <= '0;
					if (req_valid) begin
						hit_q <= 1'b0;
						lvl_q <= 1'b0;
					end
				end
				S_PASS1: begin
					pos_q <= (pos_q == LAST_POS) ? '0 : pos_q + RW'(1);
					if (id_hit) hit_q <= 1'b1;
					if (lvl_hit) lvl_q <= 1'b1;
					if (pos_q == LAST_POS) begin
						ins_q    <= 1'b0;
						remain_q <= 1'b0;
						bbv_q    <= 1'b0;
						abv_q    <= 1'b0;
					end
				end
				S_PASS2: begin
					pos_q <= (pos_q == LAST_POS) ? '0 : pos_q + RW'(1);
					if (ins_now) ins_q <= 1'b1;
					if (remain_hit) remain_q <= 1'b1;
					if (bid_take) bbv_q <= 1'b1;
					if (ask_take) abv_q <= 1'b1;
				end
				S_FIN: begin
					if (out_free) begin
						if (add_ok) begin
							ord_cnt_q <= ord_cnt_q + OCW'(1);
							if (!lvl_q && (r_side_q == SIDE_ASK)) ask_cnt_q <= ask_cnt_q + LCW'(1);
							if (!lvl_q && (r_side_q == SIDE_BID)) bid_cnt_q <= bid_cnt_q + LCW'(1);
						end else if (cancel_ok) begin
							ord_cnt_q <= ord_cnt_q - OCW'(1);
							if (!remain_q && (f_side_q == SIDE_ASK)) ask_cnt_q <= ask_cnt_q - LCW'(1);
							if (!remain_q && (f_side_q == SIDE_BID)) bid_cnt_q <= bid_cnt_q - LCW'(1);
						end
					end
				end
				default: pos_q <= '0;
			endcase
			// response beat holds until taken
			if (fin_leave) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request capture, first pass payload and best accumulators
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && req_valid) begin
			r_cmd_q   <= req.cmd;
			r_id_q    <= req.order_id;
			r_price_q <= req.price[PB-1:0];
			r_side_q  <= req.side;
		end
		if ((state_q == S_PASS1) && id_hit) begin
			f_price_q <= h_price;
			f_side_q  <= h_side;
			f_rank_q  <= h_rank;
		end
		if ((state_q == S_PASS1) && (pos_q == LAST_POS)) begin
			bb_q  <= '0;
			ab_q  <= '0;
			bbf_q <= '0;
			abf_q <= '0;
			bbr_q <= '0;
			abr_q <= '0;
		end
		if ((state_q == S_PASS2) && bid_take) begin
			bb_q  <= y_price;
			bbf_q <= y_id;
			bbr_q <= y_rank;
		end
		if ((state_q == S_PASS2) && ask_take) begin
			ab_q  <= y_price;
			abf_q <= y_id;
			abr_q <= y_rank;
		end
		if (fin_leave) begin
			rsp_q.status       <= status;
			rsp_q.best_bid     <= 32'(bb_q);
			rsp_q.bid_valid    <= bbv_q;
			rsp_q.best_ask     <= 32'(ab_q);
			rsp_q.ask_valid    <= abv_q;
			rsp_q.bid_front_id <= bbf_q;
			rsp_q.ask_front_id <= abf_q;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

FILE: sv/limit_order_book.sv
// limit order book top level: ring of order cells and head unit
//
// usage: one request beat on req (add or cancel) gives one response beat on rsp
// carrying the status and both sides' best price and front order id.
// handshake: a beat moves when valid is high and stall is low; the receiver
// drives stall and a stalled beat holds.
// resting orders live in a ring of MAX_ORDERS cells that circulates through the
// head unit. each request takes two full turns of the ring: the first finds the
// id and the price level, the second inserts or removes the order, renumbers
// order ages and gathers best bid and ask. the S_FIN state then writes the response.
// requests are worked one at a time: a new one is taken only back in S_IDLE, so the
// request rate is set by the ring length.
// the next request is taken while the previous response still waits; if rsp is
// stalled when a result is ready, the unit waits and holds req stalled.
// reset clears all cell occupancy marks and level counts: the book is empty.
`timescale 1ns / 1ps
module limit_order_book #(
	parameter int MAX_ORDERS = lob_pkg::ORDERS_DEF,
	parameter int MAX_LEVELS = lob_pkg::LEVELS_DEF,
	parameter int PRICE_BITS = lob_pkg::PRICE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lob_pkg::req_t req,
	input  logic          req_valid,
	output logic          req_stall,
	output lob_pkg::rsp_t rsp,
	output logic          rsp_valid,
	input  logic          rsp_stall
);
	import lob_pkg::*;

	localparam int DW = 64 + PRICE_BITS + 1 + $clog2(MAX_ORDERS);

	logic          shift;
	logic          tail_vld;
	logic [DW-1:0] tail_data;
	logic          cell_vld  [MAX_ORDERS];
	logic [DW-1:0] cell_data [MAX_ORDERS];

	// ring of order cells, cell 0 feeds the head unit
	for (genvar i = 0; i < MAX_ORDERS; i++) begin : g_cell
		if (i == MAX_ORDERS - 1) begin : g_last
			lob_cell #(.DW(DW)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (shift),
				.nxt_vld  (tail_vld),
				.nxt_data (tail_data),
				.vld      (cell_vld[i]),
				.data     (cell_data[i])
			);
		end else begin : g_mid
			lob_cell #(.DW(DW)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (shift),
				.nxt_vld  (cell_vld[i+1]),
				.nxt_data (cell_data[i+1]),
				.vld      (cell_vld[i]),
				.data     (cell_data[i])
			);
		end
	end

	// sequencer and processing head
	lob_unit #(
		.MAX_ORDERS (MAX_ORDERS),
		.MAX_LEVELS (MAX_LEVELS),
		.PRICE_BITS (PRICE_BITS)
	) u_unit (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.head_vld  (cell_vld[0]),
		.head_data (cell_data[0]),
		.shift     (shift),
		.tail_vld  (tail_vld),
		.tail_data (tail_data)
	);

	// a taken request keeps the unit busy on the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken while previous one in flight");

	// the ring only turns while a request is being worked
	a_shift_busy: assert property (@(posedge clk) disable iff (!arst_n)
		shift |-> req_stall)
		else $error("ring turning while idle");

	// an empty bid side reports zeros
	a_bid_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.bid_valid) |-> ((rsp.best_bid == '0) && (rsp.bid_front_id == '0)))
		else $error("bid fields nonzero with no bid level");

	// an empty ask side reports zeros
	a_ask_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.ask_valid) |-> ((rsp.best_ask == '0) && (rsp.ask_front_id == '0)))
		else $error("ask fields nonzero with no ask level");

endmodule
